>>> sv/hsc_pkg.sv
// Shared types, codes and tables of the hall six-step commutator.
`timescale 1ns / 1ps

package hsc_pkg;

   // Item kinds carried in req_tuser
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_STOP  = 2'd2;
   localparam logic [1:0] MODE_ESTOP = 2'd3;

   // Gate driver codes
   localparam logic [1:0] DRV_OFF   = 2'd0;
   localparam logic [1:0] DRV_ON    = 2'd1;
   localparam logic [1:0] DRV_BRAKE = 2'd2;

   // Reported controller phase codes
   localparam logic [1:0] PHASE_STOP  = 2'd0;
   localparam logic [1:0] PHASE_ALIGN = 2'd1;
   localparam logic [1:0] PHASE_RUN   = 2'd2;
   localparam logic [1:0] PHASE_FAULT = 2'd3;

   // Configuration register indexes
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 16;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RUN_DUTY      = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PWM_PERIOD    = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ALIGN_DUTY    = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ALIGN_TIME    = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FALLBACK_DUTY = 3'd4;

   // Reset values
   localparam logic [7:0]  RST_RUN_DUTY      = 8'd0;
   localparam logic [15:0] RST_PWM_PERIOD    = 16'd999;
   localparam logic [7:0]  RST_ALIGN_DUTY    = 8'd80;
   localparam logic [15:0] RST_ALIGN_TIME    = 16'd100;
   localparam logic [7:0]  RST_FALLBACK_DUTY = 8'd50;
   localparam logic [7:0]  RST_LATCHED_DUTY  = 8'd50;

   // Low-side bit sets, bit 0 is phase U
   localparam logic [2:0] LOW_NONE  = 3'b000;
   localparam logic [2:0] LOW_ALIGN = 3'b110;

   // Commutation steps; STEP_NONE marks an invalid hall code
   localparam logic [2:0] STEP_NONE = 3'd6;
   localparam logic [2:0] STEP_OF_CODE [8] = '{3'd6, 3'd5, 3'd3, 3'd4,
                                              3'd1, 3'd0, 3'd2, 3'd6};

   // Phase indexes for compare registers
   localparam logic [1:0] IDX_U = 2'd0;
   localparam logic [1:0] IDX_V = 2'd1;
   localparam logic [1:0] IDX_W = 2'd2;

   typedef enum logic [3:0] {
      ST_STOP  = 4'b0001,
      ST_ALIGN = 4'b0010,
      ST_RUN   = 4'b0100,
      ST_FAULT = 4'b1000
   } ctrl_state_type;

   typedef enum logic [1:0] {
      UPD_KEEP  = 2'd0,
      UPD_ALIGN = 2'd1,
      UPD_STEP  = 2'd2
   } upd_type;

   // Per-item control info that travels down the compare pipeline
   typedef struct packed {
      logic [1:0] driver;
      logic [1:0] phase;
      logic [2:0] hall;
      logic [2:0] low;
      upd_type    upd;
      logic [1:0] sel;
   } tag_type;

   typedef struct packed {
      tag_type    tag;
      logic [7:0] duty;
   } decision_type;

   function automatic logic [1:0] step_index(input logic [2:0] step);
      logic [1:0] idx;
      case (step)
         3'd0, 3'd1: idx = IDX_U;
         3'd2, 3'd3: idx = IDX_W;
         default:    idx = IDX_V;
      endcase
      return idx;
   endfunction

   function automatic logic [2:0] step_low(input logic [2:0] step);
      logic [2:0] low;
      case (step)
         3'd1, 3'd2: low = 3'b010;
         3'd3, 3'd4: low = 3'b001;
         default:    low = 3'b100;
      endcase
      return low;
   endfunction

   function automatic logic [1:0] phase_code(input ctrl_state_type st);
      logic [1:0] code;
      case (st)
         ST_ALIGN: code = PHASE_ALIGN;
         ST_RUN:   code = PHASE_RUN;
         ST_FAULT: code = PHASE_FAULT;
         default:  code = PHASE_STOP;
      endcase
      return code;
   endfunction

endpackage

>>> sv/hsc_ctrl.sv
// Controller state machine: command handling, alignment timing, step choice.
`timescale 1ns / 1ps

module hsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [1:0]           mode,
   input  logic [2:0]           hall,
   input  logic [31:0]          now_ms,
   input  logic [7:0]           run_duty,
   input  logic [7:0]           align_duty,
   input  logic [15:0]          align_time,
   input  logic [7:0]           fallback_duty,
   output hsc_pkg::decision_type decision
);

   hsc_pkg::ctrl_state_type state_ff, state_in;
   logic [7:0]  duty_ff, duty_in;
   logic [31:0] begin_ff, begin_in;
   logic [2:0]  low_ff, low_in;
   logic [1:0]  driver_ff, driver_in;
   logic [31:0] elapsed;
   logic [2:0]  step;

   assign elapsed = now_ms - begin_ff;
   assign step    = hsc_pkg::STEP_OF_CODE[hall];

   always_comb begin
      state_in  = state_ff;
      duty_in   = duty_ff;
      begin_in  = begin_ff;
      low_in    = low_ff;
      driver_in = driver_ff;
      decision.tag.upd = hsc_pkg::UPD_KEEP;
      decision.tag.sel = hsc_pkg::IDX_U;
      decision.duty    = duty_ff;
      case (mode)
         hsc_pkg::MODE_START: begin
            if (state_ff == hsc_pkg::ST_STOP) begin
               driver_in = hsc_pkg::DRV_ON;
               state_in  = hsc_pkg::ST_ALIGN;
               duty_in   = (run_duty != 8'd0) ? run_duty : fallback_duty;
               begin_in  = now_ms;
            end
         end
         hsc_pkg::MODE_STOP: begin
            driver_in = hsc_pkg::DRV_OFF;
            state_in  = hsc_pkg::ST_STOP;
         end
         hsc_pkg::MODE_ESTOP: begin
            driver_in = hsc_pkg::DRV_BRAKE;
            state_in  = hsc_pkg::ST_FAULT;
         end
         default: begin
            if (state_ff == hsc_pkg::ST_ALIGN) begin
               if (elapsed < {16'd0, align_time}) begin
                  low_in = hsc_pkg::LOW_ALIGN;
                  decision.tag.upd = hsc_pkg::UPD_ALIGN;
                  decision.duty    = align_duty;
               end else begin
                  state_in = hsc_pkg::ST_RUN;
               end
            end else if (state_ff == hsc_pkg::ST_RUN && step != hsc_pkg::STEP_NONE) begin
               low_in = hsc_pkg::step_low(step);
               decision.tag.upd = hsc_pkg::UPD_STEP;
               decision.tag.sel = hsc_pkg::step_index(step);
            end
         end
      endcase
      decision.tag.driver = driver_in;
      decision.tag.phase  = hsc_pkg::phase_code(state_in);
      decision.tag.hall   = hall;
      decision.tag.low    = low_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= hsc_pkg::ST_STOP;
         duty_ff   <= hsc_pkg::RST_LATCHED_DUTY;
         begin_ff  <= 32'd0;
         low_ff    <= hsc_pkg::LOW_NONE;
         driver_ff <= hsc_pkg::DRV_OFF;
      end else if (advance) begin
         state_ff  <= state_in;
         duty_ff   <= duty_in;
         begin_ff  <= begin_in;
         low_ff    <= low_in;
         driver_ff <= driver_in;
      end
   end

endmodule

>>> sv/hall_six_step_commutator.sv
// Top level of the hall six-step commutator: input stage, compare pipeline, output register.
// Throughput: one item per cycle while rsp_tready does not stall the output; the five-stage
// pipeline (input register, control decision, duty*period multiply, divide-by-255 estimate,
// correction) holds one item per stage.
// Each stage loads when it is empty or its successor loads, so bubbles are filled under stall.
// Reset (synchronous, active high) empties the pipeline, restores the configuration
// defaults, puts the controller in stop with the driver off and clears compares and low sides.
`timescale 1ns / 1ps

module hall_six_step_commutator #(
   parameter int COMPARE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // Command and hall item
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [39:0]                         req_tdata,  // hall_u, hall_v, hall_w, now_ms[31:0]
   input  logic [1:0]                          req_tuser,  // mode
   // Result item
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [63:0]                         rsp_tdata,  // compare_u, compare_v, compare_w,
                                                           // low_u, low_v, low_w, driver_mode,
                                                           // motor_phase, hall_code
   // Configuration writes
   input  logic                                csr_we,
   input  logic [hsc_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [hsc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   // Scaled compares are cut to COMPARE_BITS and then to the 16-bit field
   localparam logic [15:0] CMP_MASK = (COMPARE_BITS >= 16) ? 16'hFFFF :
                                      16'((32'd1 << COMPARE_BITS) - 32'd1);

   // Configuration registers
   logic [7:0]  run_duty_ff;
   logic [15:0] pwm_period_ff;
   logic [7:0]  align_duty_ff;
   logic [15:0] align_time_ff;
   logic [7:0]  fallback_duty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_duty_ff      <= hsc_pkg::RST_RUN_DUTY;
         pwm_period_ff    <= hsc_pkg::RST_PWM_PERIOD;
         align_duty_ff    <= hsc_pkg::RST_ALIGN_DUTY;
         align_time_ff    <= hsc_pkg::RST_ALIGN_TIME;
         fallback_duty_ff <= hsc_pkg::RST_FALLBACK_DUTY;
      end else if (csr_we) begin
         case (csr_addr)
            hsc_pkg::CSR_RUN_DUTY:      run_duty_ff      <= csr_wdata[7:0];
            hsc_pkg::CSR_PWM_PERIOD:    pwm_period_ff    <= csr_wdata;
            hsc_pkg::CSR_ALIGN_DUTY:    align_duty_ff    <= csr_wdata[7:0];
            hsc_pkg::CSR_ALIGN_TIME:    align_time_ff    <= csr_wdata;
            hsc_pkg::CSR_FALLBACK_DUTY: fallback_duty_ff <= csr_wdata[7:0];
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   // Stage valid flags and load enables. A stage loads when it is empty or
   // when the stage after it loads in the same cycle.
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic ready0, ready1, ready2, ready3, ready4;

   assign ready4 = !v4_ff || rsp_tready;
   assign ready3 = !v3_ff || ready4;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;
   assign ready0 = !v0_ff || ready1;

   assign req_tready = ready0;
   assign rsp_tvalid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ready0) v0_ff <= req_tvalid;
         if (ready1) v1_ff <= v0_ff;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
         if (ready4) v4_ff <= v3_ff;
      end
   end

   // Stage 0: input register; pack the hall pins as code = 2*u + v + 4*w
   logic [1:0]  s0_mode_ff;
   logic [2:0]  s0_hall_ff;
   logic [31:0] s0_now_ff;

   always_ff @(posedge clock) begin
      if (ready0) begin
         s0_mode_ff <= req_tuser;
         s0_hall_ff <= {req_tdata[2], req_tdata[0], req_tdata[1]};
         s0_now_ff  <= req_tdata[34:3];
      end
   end

   // Stage 0 -> 1: controller advances exactly once per item, in item order
   hsc_pkg::decision_type decision;

   hsc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .advance       (ready1 && v0_ff),
      .mode          (s0_mode_ff),
      .hall          (s0_hall_ff),
      .now_ms        (s0_now_ff),
      .run_duty      (run_duty_ff),
      .align_duty    (align_duty_ff),
      .align_time    (align_time_ff),
      .fallback_duty (fallback_duty_ff),
      .decision      (decision)
   );

   // Stage 1: decision, duty and period snapshot
   hsc_pkg::tag_type s1_tag_ff;
   logic [7:0]       s1_duty_ff;
   logic [15:0]      s1_period_ff;

   always_ff @(posedge clock) begin
      if (ready1) begin
         s1_tag_ff    <= decision.tag;
         s1_duty_ff   <= decision.duty;
         s1_period_ff <= pwm_period_ff;
      end
   end

   // Stage 2: product duty * period, at most 24 bits
   hsc_pkg::tag_type s2_tag_ff;
   logic [23:0]      s2_prod_ff;

   always_ff @(posedge clock) begin
      if (ready2) begin
         s2_tag_ff  <= s1_tag_ff;
         s2_prod_ff <= 24'(s1_duty_ff) * 24'(s1_period_ff);
      end
   end

   // Stage 3: estimate x/255 as (x + x/256 + x/65536) / 256. The estimate never
   // exceeds the true quotient and falls short by at most one.
   hsc_pkg::tag_type s3_tag_ff;
   logic [23:0]      s3_x_ff;
   logic [15:0]      s3_q0_ff;
   logic [23:0]      est_sum;

   assign est_sum = s2_prod_ff + {8'd0, s2_prod_ff[23:8]} + {16'd0, s2_prod_ff[23:16]};

   always_ff @(posedge clock) begin
      if (ready3) begin
         s3_tag_ff <= s2_tag_ff;
         s3_x_ff   <= s2_prod_ff;
         s3_q0_ff  <= est_sum[23:8];
      end
   end

   // Stage 3 -> 4: remainder x - 255*q0 lies in [0, 510); bump the quotient when
   // it reaches 255.
   logic [23:0] remainder;
   logic [15:0] quotient;
   logic [15:0] scaled;

   assign remainder = s3_x_ff - {s3_q0_ff, 8'd0} + {8'd0, s3_q0_ff};
   assign quotient  = s3_q0_ff + {15'd0, (remainder >= 24'd255)};
   assign scaled    = quotient & CMP_MASK;

   // Stage 4: output register. Compares are held state here: an item that
   // touches no compare keeps the values left by the item before it.
   hsc_pkg::tag_type out_tag_ff;
   logic [15:0]      cmp_ff [3];

   always_ff @(posedge clock) begin
      if (ready4 && v3_ff) begin
         out_tag_ff <= s3_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_ff[0] <= 16'd0;
         cmp_ff[1] <= 16'd0;
         cmp_ff[2] <= 16'd0;
      end else if (ready4 && v3_ff) begin
         case (s3_tag_ff.upd)
            hsc_pkg::UPD_ALIGN: begin
               cmp_ff[0] <= scaled;
               cmp_ff[1] <= 16'd0;
               cmp_ff[2] <= 16'd0;
            end
            hsc_pkg::UPD_STEP: begin
               cmp_ff[0] <= (s3_tag_ff.sel == hsc_pkg::IDX_U) ? scaled : 16'd0;
               cmp_ff[1] <= (s3_tag_ff.sel == hsc_pkg::IDX_V) ? scaled : 16'd0;
               cmp_ff[2] <= (s3_tag_ff.sel == hsc_pkg::IDX_W) ? scaled : 16'd0;
            end
            default: ;  // hold compares
         endcase
      end
   end

   assign rsp_tdata = {6'd0,
                       out_tag_ff.hall,
                       out_tag_ff.phase,
                       out_tag_ff.driver,
                       out_tag_ff.low,
                       cmp_ff[2],
                       cmp_ff[1],
                       cmp_ff[0]};

endmodule

>>> sv/hsc_checker.sv
// Port-level checker for the hall six-step commutator, bound to the top level.
`timescale 1ns / 1ps

module hsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   logic [15:0] cmp_v, cmp_w;
   logic [2:0]  low;
   logic [1:0]  drv, phase;

   assign cmp_v = rsp_tdata[31:16];
   assign cmp_w = rsp_tdata[47:32];
   assign low   = rsp_tdata[50:48];
   assign drv   = rsp_tdata[52:51];
   assign phase = rsp_tdata[54:53];

   // Pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result holds its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // An empty output stage never blocks input
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty pipeline");

   // Fault and braking go together, stop and driver off go together
   a_drv_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((phase == hsc_pkg::PHASE_FAULT) == (drv == hsc_pkg::DRV_BRAKE))
                  && ((phase == hsc_pkg::PHASE_STOP) == (drv == hsc_pkg::DRV_OFF)))
      else $error("driver mode disagrees with phase");

   // Alignment low sides come only with V and W compares at zero
   a_align_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && low == hsc_pkg::LOW_ALIGN |-> cmp_v == 16'd0 && cmp_w == 16'd0)
      else $error("alignment pattern with nonzero V or W compare");

endmodule

bind hall_six_step_commutator hsc_checker u_hsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
